// ===== rtl/npl_pkg.sv =====
package npl_pkg;

    localparam int SAMPLE_W             = 16;
    localparam int LEVEL_W              = 16;
    localparam int FRAMES_MAX_W         = 17;
    localparam int HISTORY_DEPTH_DEF    = 6;
    localparam int MAX_CHUNK_FRAMES_DEF = 1024;
    localparam int QUEUE_DEPTH          = 2;

    // quotient of chunk * 2^30 / running, at most 2^30
    localparam int FRAC_BITS  = 30;
    localparam int QUOT_W     = FRAC_BITS + 1;
    localparam int DIV_STEPS  = QUOT_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int SQRT_STEPS = (QUOT_W + 1) / 2;
    localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);

    // one finished chunk handed from the front to the back
    typedef struct packed {
        logic [LEVEL_W-1:0]      chunk_peak;
        logic [LEVEL_W-1:0]      running_peak;
        logic [FRAMES_MAX_W-1:0] frames;
    } chunk_rec_t;

    // magnitude of a 16-bit two's complement sample, -32768 gives 32768
    function automatic logic [LEVEL_W-1:0] magnitude(input logic [SAMPLE_W-1:0] s);
        logic [LEVEL_W-1:0] m;
        begin
            m = s[SAMPLE_W-1] ? LEVEL_W'(~s + 1'b1) : LEVEL_W'(s);
            return m;
        end
    endfunction

    function automatic logic [LEVEL_W-1:0] max16(input logic [LEVEL_W-1:0] a,
                                                 input logic [LEVEL_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ===== rtl/npl_frame_if.sv =====
interface npl_frame_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               chunk_end;

    modport source (output valid, output left_sample, output right_sample,
                    output chunk_end, input ready);
    modport sink   (input valid, input left_sample, input right_sample,
                    input chunk_end, output ready);
endinterface

// ===== rtl/npl_level_if.sv =====
interface npl_level_if #(
    parameter int FRAMES_W = 11
);
    logic                valid;
    logic                ready;
    logic [15:0]         peak_level;
    logic [15:0]         chunk_level;
    logic [FRAMES_W-1:0] chunk_frames;

    modport source (output valid, output peak_level, output chunk_level,
                    output chunk_frames, input ready);
    modport sink   (input valid, input peak_level, input chunk_level,
                    input chunk_frames, output ready);
endinterface

// ===== rtl/npl_front.sv =====
module npl_front #(
    parameter int MAX_CHUNK_FRAMES = 1024,
    parameter int FRAMES_W         = 11
) (
    input  logic                 clk,
    input  logic                 rst_n,
    npl_frame_if.sink            frame,
    input  logic                 queue_full,
    output logic                 push,
    output npl_pkg::chunk_rec_t  push_rec
);
    import npl_pkg::*;

    logic [LEVEL_W-1:0]  chunk_peak_reg, chunk_peak_next;
    logic [LEVEL_W-1:0]  running_peak_reg, running_peak_next;
    logic [FRAMES_W-1:0] frame_count_reg, frame_count_next;
    logic [LEVEL_W-1:0]  peak_now;
    logic [LEVEL_W-1:0]  running_now;
    logic [FRAMES_W-1:0] count_now;
    logic                accept;

    assign frame.ready = !queue_full;
    assign accept      = frame.valid && frame.ready;

    always_comb
    begin
        peak_now    = max16(chunk_peak_reg,
                            max16(magnitude(frame.left_sample), magnitude(frame.right_sample)));
        running_now = max16(running_peak_reg, peak_now);
        count_now   = (frame_count_reg < FRAMES_W'(MAX_CHUNK_FRAMES))
                      ? frame_count_reg + 1'b1 : frame_count_reg;

        chunk_peak_next   = chunk_peak_reg;
        running_peak_next = running_peak_reg;
        frame_count_next  = frame_count_reg;
        if (accept)
        begin
            if (frame.chunk_end)
            begin
                chunk_peak_next   = '0;
                running_peak_next = running_now;
                frame_count_next  = '0;
            end
            else
            begin
                chunk_peak_next  = peak_now;
                frame_count_next = count_now;
            end
        end

        push                  = accept && frame.chunk_end;
        push_rec.chunk_peak   = peak_now;
        push_rec.running_peak = running_now;
        push_rec.frames       = FRAMES_MAX_W'(count_now);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_peak_reg   <= '0;
            running_peak_reg <= '0;
            frame_count_reg  <= '0;
        end
        else
        begin
            chunk_peak_reg   <= chunk_peak_next;
            running_peak_reg <= running_peak_next;
            frame_count_reg  <= frame_count_next;
        end
    end

endmodule

// ===== rtl/npl_queue.sv =====
module npl_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  npl_pkg::chunk_rec_t  push_rec,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output npl_pkg::chunk_rec_t  pop_rec
);
    import npl_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    chunk_rec_t       slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_rec   = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/npl_back.sv =====
module npl_back #(
    parameter int HISTORY_DEPTH = 6,
    parameter int FRAMES_W      = 11
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 not_empty,
    input  npl_pkg::chunk_rec_t  pop_rec,
    output logic                 pop,
    npl_level_if.source          level
);
    import npl_pkg::*;

    localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_SQRT = 5'b00100,
        S_SCAN = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [LEVEL_W-1:0]  history_reg [HISTORY_DEPTH];
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [SLOT_W-1:0]   scan_idx_reg, scan_idx_next;
    logic [LEVEL_W-1:0]  max_reg, max_next;

    logic [LEVEL_W-1:0]  divisor_reg, divisor_next;
    logic [LEVEL_W:0]    rem_reg, rem_next;
    logic [QUOT_W-1:0]   quot_reg, quot_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    logic [QUOT_W-1:0]   rad_reg, rad_next;
    logic [QUOT_W-1:0]   root_reg, root_next;
    logic [QUOT_W-1:0]   bit_reg, bit_next;
    logic [SQRT_CNT_W-1:0] sqrt_cnt_reg, sqrt_cnt_next;

    logic [FRAMES_W-1:0] frames_reg, frames_next;

    logic                out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0]  out_peak_reg, out_peak_next;
    logic [LEVEL_W-1:0]  out_level_reg, out_level_next;
    logic [FRAMES_W-1:0] out_frames_reg, out_frames_next;

    logic [LEVEL_W:0]    trial;
    logic                div_ge;
    logic [QUOT_W:0]     sqrt_sum;
    logic                sqrt_ge;
    logic                hist_we;

    assign level.valid        = out_valid_reg;
    assign level.peak_level   = out_peak_reg;
    assign level.chunk_level  = out_level_reg;
    assign level.chunk_frames = out_frames_reg;

    always_comb
    begin
        // restoring divide, the first step compares without a shift
        trial    = (div_cnt_reg == '0) ? rem_reg : {rem_reg[LEVEL_W-1:0], 1'b0};
        div_ge   = (trial >= {1'b0, divisor_reg});
        // bit-pair square root, one result bit a step
        sqrt_sum = {1'b0, root_reg} + {1'b0, bit_reg};
        sqrt_ge  = ({1'b0, rad_reg} >= sqrt_sum);

        state_next      = state_reg;
        slot_next       = slot_reg;
        scan_idx_next   = scan_idx_reg;
        max_next        = max_reg;
        divisor_next    = divisor_reg;
        rem_next        = rem_reg;
        quot_next       = quot_reg;
        div_cnt_next    = div_cnt_reg;
        rad_next        = rad_reg;
        root_next       = root_reg;
        bit_next        = bit_reg;
        sqrt_cnt_next   = sqrt_cnt_reg;
        frames_next     = frames_reg;
        out_valid_next  = out_valid_reg;
        out_peak_next   = out_peak_reg;
        out_level_next  = out_level_reg;
        out_frames_next = out_frames_reg;
        pop             = 1'b0;
        hist_we         = 1'b0;

        if (out_valid_reg && level.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (not_empty)
                begin
                    pop          = 1'b1;
                    divisor_next = pop_rec.running_peak;
                    rem_next     = {1'b0, pop_rec.chunk_peak};
                    quot_next    = '0;
                    div_cnt_next = '0;
                    frames_next  = FRAMES_W'(pop_rec.frames);
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next     = div_ge ? trial - {1'b0, divisor_reg} : trial;
                quot_next    = {quot_reg[QUOT_W-2:0], div_ge};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    // silent stream so far gives a level of zero
                    rad_next      = (divisor_reg == '0) ? '0
                                    : {quot_reg[QUOT_W-2:0], div_ge};
                    root_next     = '0;
                    bit_next      = QUOT_W'(1) << FRAC_BITS;
                    sqrt_cnt_next = '0;
                    state_next    = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sqrt_ge)
                begin
                    rad_next  = rad_reg - QUOT_W'(sqrt_sum);
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next      = bit_reg >> 2;
                sqrt_cnt_next = sqrt_cnt_reg + 1'b1;
                if (sqrt_cnt_reg == SQRT_CNT_W'(SQRT_STEPS - 1))
                begin
                    hist_we       = 1'b1;
                    slot_next     = (slot_reg == SLOT_W'(HISTORY_DEPTH - 1))
                                    ? '0 : slot_reg + 1'b1;
                    scan_idx_next = '0;
                    max_next      = '0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                max_next      = max16(max_reg, history_reg[scan_idx_reg]);
                scan_idx_next = scan_idx_reg + 1'b1;
                if (scan_idx_reg == SLOT_W'(HISTORY_DEPTH - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || level.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_peak_next   = max_reg;
                    out_level_next  = root_reg[LEVEL_W-1:0];
                    out_frames_next = frames_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // root is at most 2^15 after the last step, so the low bits hold it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                history_reg[i] <= '0;
            end
        end
        else if (hist_we)
        begin
            history_reg[slot_reg] <= root_next[LEVEL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg   <= scan_idx_next;
        max_reg        <= max_next;
        divisor_reg    <= divisor_next;
        rem_reg        <= rem_next;
        quot_reg       <= quot_next;
        div_cnt_reg    <= div_cnt_next;
        rad_reg        <= rad_next;
        root_reg       <= root_next;
        bit_reg        <= bit_next;
        sqrt_cnt_reg   <= sqrt_cnt_next;
        frames_reg     <= frames_next;
        out_peak_reg   <= out_peak_next;
        out_level_reg  <= out_level_next;
        out_frames_reg <= out_frames_next;
    end

endmodule

// ===== rtl/normalized_peak_level_meter.sv =====
// channel   dir   word fields                                  handshake
// frame     in    left_sample, right_sample, chunk_end          valid / ready
// level     out   peak_level, chunk_level, chunk_frames         valid / ready
//
// frames are taken one per cycle while the queue has room; a frame with chunk_end goes into a two-entry queue
// the back end takes each chunk from the queue through a one-bit-a-cycle
// divider, a one-bit-a-cycle square root, then a scan of the history ring, one entry a cycle
// frame.ready drops only while the queue is full; the back end waits in its last state
// while a finished word still sits in the output register
// rst_n clears the frame count, the chunk and running peaks, the history ring and the queue at once
module normalized_peak_level_meter #(
    parameter int HISTORY_DEPTH    = npl_pkg::HISTORY_DEPTH_DEF,
    parameter int MAX_CHUNK_FRAMES = npl_pkg::MAX_CHUNK_FRAMES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    npl_frame_if.sink    frame,
    npl_level_if.source  level
);
    import npl_pkg::*;

    localparam int FRAMES_W = $clog2(MAX_CHUNK_FRAMES + 1);

    chunk_rec_t push_rec;
    chunk_rec_t pop_rec;
    logic       push;
    logic       pop;
    logic       queue_full;
    logic       not_empty;

    npl_front #(
        .MAX_CHUNK_FRAMES (MAX_CHUNK_FRAMES),
        .FRAMES_W         (FRAMES_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame      (frame),
        .queue_full (queue_full),
        .push       (push),
        .push_rec   (push_rec)
    );

    npl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rec  (push_rec),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_rec   (pop_rec)
    );

    npl_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .FRAMES_W      (FRAMES_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .pop_rec   (pop_rec),
        .pop       (pop),
        .level     (level)
    );

endmodule

// ===== bench/normalized_peak_level_meter_tb.sv =====
`timescale 1ns / 1ps

module normalized_peak_level_meter_tb;

    import npl_pkg::*;

    localparam int HIST       = HISTORY_DEPTH_DEF;
    localparam int MAX_FRAMES = MAX_CHUNK_FRAMES_DEF;
    localparam int FRAMES_W   = 11;
    localparam int RANDOM_ITEMS = 2000;
    localparam int DRAIN_CYCLES = 120;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] l_smp;
        logic signed [SAMPLE_W-1:0] r_smp;
        logic                       last;
    } frame_word_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]  peak;
        logic [LEVEL_W-1:0]  level;
        logic [FRAMES_W-1:0] frames;
    } level_word_t;

    logic clk = 1'b0;
    logic rst_n;

    npl_frame_if                        frame_bus ();
    npl_level_if #(.FRAMES_W(FRAMES_W)) level_bus ();

    normalized_peak_level_meter u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .frame (frame_bus),
        .level (level_bus)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // stimulus and expected results
    frame_word_t frames_todo[$];
    level_word_t levels_due[$];
    bit          failed = 1'b0;

    // predictor state
    int unsigned        pk_chunk;
    int unsigned        pk_running;
    int unsigned        frames_seen;
    logic [LEVEL_W-1:0] ring[HIST];
    int                 ring_slot;

    function automatic int unsigned sample_mag(input logic signed [SAMPLE_W-1:0] s);
        return (s < 0) ? int'(-int'(s)) : int'(s);
    endfunction

    // largest r with r*r <= x, one bit at a time from the top
    function automatic logic [LEVEL_W-1:0] floor_root(input longint unsigned x);
        logic [LEVEL_W-1:0] r;
        logic [LEVEL_W-1:0] trial;
        int                 b;
        r = '0;
        for (b = LEVEL_W - 1; b >= 0; b--)
        begin
            trial = r | (LEVEL_W'(1) << b);
            if (longint'(trial) * longint'(trial) <= x)
                r = trial;
        end
        return r;
    endfunction

    task automatic meter_clear();
        int i;
        pk_chunk    = 0;
        pk_running  = 0;
        frames_seen = 0;
        ring_slot   = 0;
        for (i = 0; i < HIST; i++)
            ring[i] = '0;
    endtask

    task automatic meter_step(input frame_word_t w);
        int unsigned        ml;
        int unsigned        mr;
        longint unsigned    q30;
        logic [LEVEL_W-1:0] top;
        level_word_t        res;
        int                 i;
        ml = sample_mag(w.l_smp);
        mr = sample_mag(w.r_smp);
        if (ml > pk_chunk)
            pk_chunk = ml;
        if (mr > pk_chunk)
            pk_chunk = mr;
        if (frames_seen < MAX_FRAMES)
            frames_seen++;
        if (w.last)
        begin
            if (pk_chunk > pk_running)
                pk_running = pk_chunk;
            q30 = 0;
            if (pk_running != 0)
                q30 = (longint'(pk_chunk) << FRAC_BITS) / longint'(pk_running);
            res.level = floor_root(q30);
            ring[ring_slot] = res.level;
            ring_slot = (ring_slot + 1) % HIST;
            top = '0;
            for (i = 0; i < HIST; i++)
                if (ring[i] > top)
                    top = ring[i];
            res.peak   = top;
            res.frames = FRAMES_W'(frames_seen);
            levels_due.push_back(res);
            pk_chunk    = 0;
            frames_seen = 0;
        end
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
            failed = 1'b1;
        end
    endtask

    // short gaps mostly, long ones now and then, none at all in calm stretches
    function automatic int unsigned pick_gap(input bit busy);
        int unsigned roll;
        if (!busy)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(12, 50);
    endfunction

    // compare and predict from one edge so ordering never matters
    bit frame_fire;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_fire <= 1'b0;
            meter_clear();
        end
        else
        begin
            frame_fire <= frame_bus.valid && frame_bus.ready;
            if (level_bus.valid && level_bus.ready)
            begin
                if (levels_due.size() == 0)
                begin
                    $display("%0t unexpected word: expected none, actual %0d %0d %0d", $time,
                             level_bus.peak_level, level_bus.chunk_level,
                             level_bus.chunk_frames);
                    failed = 1'b1;
                end
                else
                begin
                    level_word_t exp_w;
                    exp_w = levels_due.pop_front();
                    check_field("peak_level", exp_w.peak, level_bus.peak_level);
                    check_field("chunk_level", exp_w.level, level_bus.chunk_level);
                    check_field("chunk_frames", exp_w.frames, level_bus.chunk_frames);
                end
            end
            if (frame_bus.valid && frame_bus.ready)
                meter_step({frame_bus.left_sample, frame_bus.right_sample,
                            frame_bus.chunk_end});
        end
    end

    // frame driver
    frame_word_t next_word;
    int unsigned send_gap    = 0;
    bit          src_busy    = 1'b1;
    int unsigned src_phase   = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
            frame_bus.valid <= 1'b0;
        else
        begin
            if (src_phase == 0)
            begin
                src_busy  <= ($urandom_range(0, 2) != 0);
                src_phase <= $urandom_range(50, 300);
            end
            else
                src_phase <= src_phase - 1;
            if (!frame_bus.valid || frame_fire)
            begin
                if (send_gap != 0)
                begin
                    frame_bus.valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (frames_todo.size() != 0)
                begin
                    next_word = frames_todo.pop_front();
                    frame_bus.valid        <= 1'b1;
                    frame_bus.left_sample  <= next_word.l_smp;
                    frame_bus.right_sample <= next_word.r_smp;
                    frame_bus.chunk_end    <= next_word.last;
                    send_gap <= pick_gap(src_busy);
                end
                else
                    frame_bus.valid <= 1'b0;
            end
        end
    end

    // level sink stalls
    int unsigned stall_left = 0;
    bit          snk_busy   = 1'b1;
    int unsigned snk_phase  = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
            level_bus.ready <= 1'b0;
        else
        begin
            if (snk_phase == 0)
            begin
                snk_busy  <= ($urandom_range(0, 2) != 0);
                snk_phase <= $urandom_range(50, 300);
            end
            else
                snk_phase <= snk_phase - 1;
            if (stall_left != 0)
            begin
                level_bus.ready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else
            begin
                level_bus.ready <= 1'b1;
                if (snk_busy && $urandom_range(0, 3) == 0)
                    stall_left <= pick_gap(1'b1);
            end
        end
    end

    task automatic push_frame(input logic signed [SAMPLE_W-1:0] l, input logic signed [SAMPLE_W-1:0] r,
                              input logic last);
        frame_word_t w;
        w.l_smp = l;
        w.r_smp = r;
        w.last  = last;
        frames_todo.push_back(w);
    endtask

    // sample bounded by 2^k - 1, with full range and the extremes mixed in
    function automatic logic signed [SAMPLE_W-1:0] rand_sample(input int k);
        int unsigned roll;
        int          m;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            return 16'sh8000;
        if (roll == 1)
            return 16'sh7FFF;
        if (roll == 2)
            return '0;
        if (k >= 16)
            return SAMPLE_W'($urandom);
        m = $urandom_range(0, (1 << k) - 1);
        return $urandom_range(0, 1) ? SAMPLE_W'(-m) : SAMPLE_W'(m);
    endfunction

    task automatic push_chunk(input int unsigned len, input int k);
        int unsigned i;
        for (i = 1; i <= len; i++)
            push_frame(rand_sample(k), rand_sample(k), i == len);
    endtask

    initial
    begin
        int unsigned count;
        int unsigned len;
        int unsigned roll;
        bit          long_done;

        rst_n                  = 1'b0;
        frame_bus.valid        = 1'b0;
        frame_bus.left_sample  = '0;
        frame_bus.right_sample = '0;
        frame_bus.chunk_end    = 1'b0;
        level_bus.ready        = 1'b0;

        // silent stream, then tiny peaks that set the running max low
        push_frame(16'sd0, 16'sd0, 1'b0);
        push_frame(16'sd0, 16'sd0, 1'b1);
        push_frame(16'sd1, 16'sd0, 1'b1);
        push_frame(16'sd0, -16'sd1, 1'b1);
        push_frame(16'sd0, 16'sd0, 1'b1);
        push_frame(16'sd3, -16'sd2, 1'b0);
        push_frame(16'sd1, 16'sd2, 1'b1);
        push_frame(-16'sd1, 16'sd1, 1'b1);
        push_frame(16'sd32767, -16'sd32767, 1'b1);
        push_frame(16'sh8000, 16'sd5, 1'b1);
        push_frame(16'sd32767, 16'sd0, 1'b1);
        push_frame(16'sh5555, 16'shAAAA, 1'b1);
        push_frame(16'sd1, 16'sh8000, 1'b0);
        push_frame(16'sh8000, 16'sh8000, 1'b1);
        // zero chunks push the old levels out of the ring
        repeat (HIST)
            push_frame(16'sd0, 16'sd0, 1'b1);

        count     = 0;
        long_done = 1'b0;
        while (count < RANDOM_ITEMS)
        begin
            if (!long_done && count > RANDOM_ITEMS / 3)
            begin
                // chunk longer than the frame counter can report
                len = $urandom_range(MAX_FRAMES + 1, MAX_FRAMES + 40);
                long_done = 1'b1;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 40)
                    len = 1;
                else if (roll < 85)
                    len = $urandom_range(2, 6);
                else
                    len = $urandom_range(7, 40);
            end
            push_chunk(len, $urandom_range(0, 16));
            count += len;
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (frames_todo.size() != 0 || frame_bus.valid)
            @(posedge clk);
        while (levels_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (!failed && levels_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/npl_pkg.sv
rtl/npl_frame_if.sv
rtl/npl_level_if.sv
rtl/npl_front.sv
rtl/npl_queue.sv
rtl/npl_back.sv
rtl/normalized_peak_level_meter.sv
bench/normalized_peak_level_meter_tb.sv
